// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Request and result payloads, action and status codes, cell control and
// the sizing functions of the registered read-out tree.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DefDepth  = 256;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PosW      = 9;
  localparam int unsigned LenW      = 9;
  localparam int unsigned ActW      = 2;
  localparam int unsigned StatW     = 2;
  localparam int unsigned TreeRadix = 16;

  // action codes
  localparam logic [ActW-1:0] ActRead   = 2'd0;
  localparam logic [ActW-1:0] ActInsert = 2'd1;
  localparam logic [ActW-1:0] ActDelete = 2'd2;

  // status codes
  localparam logic [StatW-1:0] StatDone  = 2'd0;
  localparam logic [StatW-1:0] StatRange = 2'd1;
  localparam logic [StatW-1:0] StatFull  = 2'd2;

  typedef struct packed {
    logic [ActW-1:0]         action;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic signed [DataW-1:0] read_value;
    logic [LenW-1:0]         list_length;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

  // node count of tree level lvl (level 0 holds the leaves)
  function automatic int tree_cnt(int n, int lvl);
    int c;
    c = n;
    for (int i = 0; i < lvl; i++) begin
      c = (c + TreeRadix - 1) / TreeRadix;
    end
    return c;
  endfunction

  // number of registered levels down to a single root
  function automatic int tree_levels(int n);
    int c;
    int l;
    c = n;
    l = 0;
    do begin
      c = (c + TreeRadix - 1) / TreeRadix;
      l++;
    end while (c > 1);
    return l;
  endfunction

  // first flat node index of registered level lvl (from 1)
  function automatic int tree_off(int n, int lvl);
    int s;
    s = 0;
    for (int k = 1; k < lvl; k++) begin
      s += tree_cnt(n, k);
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list chain
// Holds one word; on an insert it takes its lower neighbour's word (or the
// new word at the target slot), on a delete its upper neighbour's word.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned IDX_W = 8
) (
  input  logic                     clk_i,
  input  ple_pkg::cell_ctrl_t      ctrl_i,
  input  logic [IDX_W-1:0]         cell_idx_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [ple_pkg::DataW-1:0] new_i,
  input  logic [ple_pkg::DataW-1:0] prev_i,
  input  logic [ple_pkg::DataW-1:0] next_i,
  output logic [ple_pkg::DataW-1:0] word_o,
  output logic [ple_pkg::DataW-1:0] hit_o
);
  import ple_pkg::*;

  logic [DataW-1:0] word_q, word_d;
  logic             is_eq, is_gt;

  assign is_eq = (cell_idx_i == idx_i);
  assign is_gt = (cell_idx_i > idx_i);

  // shift up on insert, shift down on delete
  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (is_eq) begin
        word_d = new_i;
      end else if (is_gt) begin
        word_d = prev_i;
      end
    end else if (ctrl_i.del) begin
      if (is_eq || is_gt) begin
        word_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  // only the addressed cell contributes to the read-out tree
  assign hit_o  = is_eq ? word_q : '0;

endmodule

// ===== rtl/core/ple_or_tree.sv =====
// ----------------------------------------------------------------------------
// ple_or_tree: registered OR-reduction tree for cell read-out
// At most one leaf is non-zero, so the root gives the addressed word after
// one register stage per tree level.
// ----------------------------------------------------------------------------
module ple_or_tree #(
  parameter int unsigned DEPTH = ple_pkg::DefDepth
) (
  input  logic                      clk_i,
  input  logic [ple_pkg::DataW-1:0] leaf_i [DEPTH],
  output logic [ple_pkg::DataW-1:0] root_o
);
  import ple_pkg::*;

  localparam int Levels = tree_levels(DEPTH);
  localparam int Nodes  = tree_off(DEPTH, Levels + 1);

  logic [DataW-1:0] node_q [Nodes];

  for (genvar l = 1; l <= Levels; l++) begin : g_lvl
    localparam int Cnt    = tree_cnt(DEPTH, l);
    localparam int CntIn  = tree_cnt(DEPTH, l - 1);
    localparam int Off    = tree_off(DEPTH, l);
    localparam int OffIn  = tree_off(DEPTH, l - 1);
    for (genvar j = 0; j < Cnt; j++) begin : g_node
      logic [DataW-1:0] kid [TreeRadix];
      logic [DataW-1:0] or_val;

      // gather the children of this node
      for (genvar c = 0; c < TreeRadix; c++) begin : g_kid
        if (j * TreeRadix + c < CntIn) begin : g_used
          if (l == 1) begin : g_leaf
            assign kid[c] = leaf_i[j * TreeRadix + c];
          end else begin : g_inner
            assign kid[c] = node_q[OffIn + j * TreeRadix + c];
          end
        end else begin : g_pad
          assign kid[c] = '0;
        end
      end

      always_comb begin
        or_val = '0;
        for (int c = 0; c < TreeRadix; c++) begin
          or_val = or_val | kid[c];
        end
      end

      always_ff @(posedge clk_i) begin
        node_q[Off + j] <= or_val;
      end
    end
  end

  assign root_o = node_q[Nodes - 1];

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed words addressed by position
// Read, insert-before and delete requests on a list held in a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, one word each; an insert or delete
// shifts every later word by one place, in all cells together. One request
// is in work at a time: it is accepted in S_IDLE, waits in S_LOOK while the
// registered radix-16 OR tree reads the addressed cell out, and is committed
// in S_DONE once the output register is free, where its result is written;
// the next request can be taken once the sequencer is back in S_IDLE. A new
// request is taken as soon as the previous one has been written to the output
// register, even if that result has not yet been transferred out. Positions
// are 1-based: position 0, a read or delete beyond the length and an insert
// beyond the length plus one give status range; an insert into a full list
// gives status full. Rejected requests leave the list untouched and return a
// zero word.
module positional_list_engine #(
  parameter int unsigned DEPTH = ple_pkg::DefDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ple_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ple_pkg::rsp_t out_data_o
);
  import ple_pkg::*;

  localparam int unsigned IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW   = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam int unsigned Levels = tree_levels(DEPTH);
  localparam int unsigned WaitW  = $clog2(Levels + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [CntW-1:0]  count_q, count_d;
  req_t             req_q;
  logic [IdxW-1:0]  idx_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_data_q, out_data_d;

  logic             in_fire, done_fire;
  cell_ctrl_t       ctrl;
  logic [DataW-1:0] word_w [DEPTH];
  logic [DataW-1:0] hit_w  [DEPTH];
  logic [DataW-1:0] root;

  logic [CmpW-1:0]  pos_w, cnt_w;
  logic             pos_nz, rd_ok, ins_ok, is_full;
  logic [StatW-1:0] status;
  logic [DataW-1:0] value;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign done_fire  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // request register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
      idx_q <= IdxW'(in_data_i.position - PosW'(1));
    end
  end

  // range and fullness checks against the current length
  assign pos_w   = CmpW'(req_q.position);
  assign cnt_w   = CmpW'(count_q);
  assign pos_nz  = (req_q.position != '0);
  assign rd_ok   = pos_nz && (pos_w <= cnt_w);
  assign ins_ok  = pos_nz && (pos_w <= cnt_w + CmpW'(1));
  assign is_full = (count_q == CntW'(DEPTH));

  always_comb begin
    status   = StatRange;
    value    = '0;
    ctrl.ins = 1'b0;
    ctrl.del = 1'b0;
    count_d  = count_q;
    unique case (req_q.action)
      ActRead: begin
        if (rd_ok) begin
          status = StatDone;
          value  = root;
        end
      end
      ActInsert: begin
        if (ins_ok) begin
          if (is_full) begin
            status = StatFull;
          end else begin
            status   = StatDone;
            ctrl.ins = done_fire;
            if (done_fire) begin
              count_d = count_q + CntW'(1);
            end
          end
        end
      end
      ActDelete: begin
        if (rd_ok) begin
          status   = StatDone;
          value    = root;
          ctrl.del = done_fire;
          if (done_fire) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      default: begin
        status = StatRange;
      end
    endcase
  end

  // sequencer: accept, wait for the tree, then commit
  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_LOOK;
          wait_d  = '0;
        end
      end
      S_LOOK: begin
        if (wait_q == WaitW'(Levels - 1)) begin
          state_d = S_DONE;
        end else begin
          wait_d = wait_q + WaitW'(1);
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      count_q <= count_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (done_fire) begin
      out_valid_d             = 1'b1;
      out_data_d.status       = status;
      out_data_d.read_value   = value;
      out_data_d.list_length  = LenW'(count_d);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // chain of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DataW-1:0] prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = req_q.item_value;
    end else begin : g_prev
      assign prev_w = word_w[k - 1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_w = word_w[k];
    end else begin : g_next
      assign next_w = word_w[k + 1];
    end

    ple_cell #(
      .IDX_W(IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (IdxW'(k)),
      .idx_i      (idx_q),
      .new_i      (req_q.item_value),
      .prev_i     (prev_w),
      .next_i     (next_w),
      .word_o     (word_w[k]),
      .hit_o      (hit_w[k])
    );
  end

  // read-out of the addressed cell
  ple_or_tree #(
    .DEPTH(DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (hit_w),
    .root_o (root)
  );

  // length never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("list length beyond depth");

  // a committed insert grows the list by exactly one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && ctrl.ins) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the list by one");

  // a rejected request leaves the length alone
  a_reject_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && status != StatDone) |=> $stable(count_q))
    else $error("rejected request changed the length");

  // a new result only ever follows a commit
  a_result_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside commit");

endmodule
